@@ hdl/sld_pkg.sv @@
// Package for the sync/length deframer: event codes, register indexes,
// and the structs passed between the tracker, result register and top level.
// No dependencies.
package sld_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned POS_W  = 16;
   localparam int unsigned EV_W   = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // event codes carried with every byte
   localparam logic [EV_W-1:0] EV_DROP     = 3'd0;
   localparam logic [EV_W-1:0] EV_START    = 3'd1;
   localparam logic [EV_W-1:0] EV_ACCEPT   = 3'd2;
   localparam logic [EV_W-1:0] EV_DONE     = 3'd3;
   localparam logic [EV_W-1:0] EV_SYNCFAIL = 3'd4;
   localparam logic [EV_W-1:0] EV_LENREJ   = 3'd5;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_LEN     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_LEN     = 2'd3;

   // header positions (position count after the byte is taken)
   localparam logic [POS_W-1:0] POS_LEN_LOW  = 16'd5;
   localparam logic [POS_W-1:0] POS_LEN_HIGH = 16'd6;
   localparam logic [POS_W-1:0] POS_MAX      = 16'hFFFF;

   localparam logic [BYTE_W-1:0] RST_SYNC_FIRST  = 8'd0;
   localparam logic [BYTE_W-1:0] RST_SYNC_SECOND = 8'd0;
   localparam logic [POS_W-1:0]  RST_MIN_LEN     = 16'd6;
   localparam logic [POS_W-1:0]  RST_MAX_LEN     = 16'd256;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_first;
      logic [BYTE_W-1:0] sync_second;
      logic [POS_W-1:0]  min_frame_len;
      logic [POS_W-1:0]  max_frame_len;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [POS_W-1:0]  byte_position;
      logic [EV_W-1:0]   event_res;
      logic [POS_W-1:0]  declared_length;
   } rsp_type;

endpackage

@@ hdl/sld_track.sv @@
// Frame tracker: position counter, captured length and the per-byte
// event decision. Depends on sld_pkg.
module sld_track
   import sld_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] rx_byte,
   input  cfg_type           cfg,
   output rsp_type           rsp
);

   logic [POS_W-1:0]  count_ff, count_in;
   logic [POS_W-1:0]  expected_ff, expected_in;
   logic [BYTE_W-1:0] len_low_ff, len_low_in;

   logic [POS_W-1:0] count_inc;
   logic [POS_W-1:0] len_word;
   logic [POS_W-1:0] expected_eff;
   logic             len_bad;

   assign count_inc    = count_ff + 16'd1;
   assign len_word     = {rx_byte, len_low_ff};
   assign len_bad      = (len_word < cfg.min_frame_len) || (len_word > cfg.max_frame_len);
   assign expected_eff = (count_inc == POS_LEN_HIGH) ? len_word : expected_ff;

   always_comb begin
      count_in    = count_ff;
      expected_in = expected_ff;
      len_low_in  = len_low_ff;
      rsp.out_byte        = rx_byte;
      rsp.byte_position   = '0;
      rsp.event_res       = EV_DROP;
      rsp.declared_length = '0;
      if (count_ff == '0) begin
         if (rx_byte == cfg.sync_first) begin
            count_in      = 16'd1;
            expected_in   = '0;
            rsp.event_res = EV_START;
         end
      end else if (count_ff == 16'd1) begin
         if (rx_byte == cfg.sync_second) begin
            count_in          = 16'd2;
            rsp.byte_position = 16'd1;
            rsp.event_res     = EV_ACCEPT;
         end else if (rx_byte == cfg.sync_first) begin
            // repeated first sync byte: restart the frame
            count_in      = 16'd1;
            expected_in   = '0;
            rsp.event_res = EV_START;
         end else begin
            count_in          = '0;
            expected_in       = '0;
            rsp.byte_position = 16'd1;
            rsp.event_res     = EV_SYNCFAIL;
         end
      end else if (count_ff == POS_MAX) begin
         // counter overflow: drop and hunt again
         count_in    = '0;
         expected_in = '0;
      end else begin
         rsp.byte_position = count_ff;
         count_in          = count_inc;
         rsp.event_res     = EV_ACCEPT;
         if (count_inc == POS_LEN_LOW) begin
            len_low_in = rx_byte;
         end
         if (count_inc == POS_LEN_HIGH && len_bad) begin
            rsp.event_res       = EV_LENREJ;
            rsp.declared_length = len_word;
            count_in            = '0;
            expected_in         = '0;
         end else begin
            expected_in         = expected_eff;
            rsp.declared_length = expected_eff;
            if (expected_eff != '0 && count_inc >= expected_eff) begin
               rsp.event_res = EV_DONE;
               count_in      = '0;
               expected_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         expected_ff <= '0;
         len_low_ff  <= '0;
      end else if (step) begin
         count_ff    <= count_in;
         expected_ff <= expected_in;
         len_low_ff  <= len_low_in;
      end
   end

   // the length is only known once the header has been counted
   a_len_after_header: assert property (@(posedge clock) disable iff (reset)
      (count_ff < POS_LEN_HIGH) |-> (expected_ff == '0))
      else $error("captured length present inside the header");

   a_start_sets_one: assert property (@(posedge clock) disable iff (reset)
      (step && rsp.event_res == EV_START) |=> (count_ff == 16'd1))
      else $error("frame start did not set position one");

   a_end_hunts: assert property (@(posedge clock) disable iff (reset)
      (step && (rsp.event_res == EV_DONE || rsp.event_res == EV_LENREJ ||
                rsp.event_res == EV_SYNCFAIL)) |=> (count_ff == '0))
      else $error("frame end did not return to hunting");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(count_ff) && $stable(expected_ff))
      else $error("tracker state moved without a transaction");

endmodule

@@ hdl/sld_out_reg.sv @@
// Result register between the tracker and the response channel.
// Depends on sld_pkg.
module sld_out_reg
   import sld_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type rsp_in,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output logic    free,
   output rsp_type rsp_out
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign free      = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_out   = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

endmodule

@@ hdl/sync_length_deframer.sv @@
// Top level of the sync/length deframer: configuration registers, tracker
// and result register. Depends on sld_pkg, sld_track and sld_out_reg.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    req_rx_byte
//   rsp      out        rsp_valid/ready    out_byte, byte_position, event_res,
//                                          declared_length
//   csr      in         csr_write_en       csr_index, csr_write_data
//
// One byte per cycle while rsp keeps up; each transaction yields one result
// in the next cycle, from the single result register after the tracker logic.
// req_ready is high whenever the result register is empty or being drained,
// so a stalled rsp side holds one result and then stalls req.
// Synchronous reset returns to hunting and loads the register defaults.
module sync_length_deframer
   import sld_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BYTE_W-1:0]     rsp_out_byte,
   output logic [POS_W-1:0]      rsp_byte_position,
   output logic [EV_W-1:0]       rsp_event_res,
   output logic [POS_W-1:0]      rsp_declared_length,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type cfg_ff, cfg_in;
   rsp_type track_rsp, out_rsp;
   logic    step;

   assign step = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_SYNC_FIRST:  cfg_in.sync_first    = csr_write_data[BYTE_W-1:0];
            REG_SYNC_SECOND: cfg_in.sync_second   = csr_write_data[BYTE_W-1:0];
            REG_MIN_LEN:     cfg_in.min_frame_len = csr_write_data[POS_W-1:0];
            REG_MAX_LEN:     cfg_in.max_frame_len = csr_write_data[POS_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first    <= RST_SYNC_FIRST;
         cfg_ff.sync_second   <= RST_SYNC_SECOND;
         cfg_ff.min_frame_len <= RST_MIN_LEN;
         cfg_ff.max_frame_len <= RST_MAX_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sld_track u_track (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (req_rx_byte),
      .cfg     (cfg_ff),
      .rsp     (track_rsp)
   );

   sld_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .rsp_in    (track_rsp),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .free      (req_ready),
      .rsp_out   (out_rsp)
   );

   assign rsp_out_byte        = out_rsp.out_byte;
   assign rsp_byte_position   = out_rsp.byte_position;
   assign rsp_event_res       = out_rsp.event_res;
   assign rsp_declared_length = out_rsp.declared_length;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Testbench for sync_length_deframer: byte stream in, tagged byte out, checked
// against an in-bench model of the sync hunt, length capture and frame count.
// Depends on sld_pkg and the deframer RTL.
module tb;
   import sld_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [BYTE_W-1:0]     rsp_out_byte;
   logic [POS_W-1:0]      rsp_byte_position;
   logic [EV_W-1:0]       rsp_event_res;
   logic [POS_W-1:0]      rsp_declared_length;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // shadow configuration and frame tracking state
   cfg_type           shadow_cfg = '{RST_SYNC_FIRST, RST_SYNC_SECOND, RST_MIN_LEN, RST_MAX_LEN};
   logic [POS_W-1:0]  frame_count = '0;
   logic [POS_W-1:0]  decl_len = '0;
   logic [BYTE_W-1:0] len_lo = '0;
   rsp_type           pending_tags[$];

   int send_idle_pct = 14;
   int rsp_idle_pct = 83;
   int hold_cycles = 0;
   int items_sent = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   sync_length_deframer uut (.*);

   always #5 clock = ~clock;

   // Work out the tag for one byte and advance the frame state.
   function automatic rsp_type deframe_byte(input logic [BYTE_W-1:0] b);
      rsp_type          r;
      logic [POS_W-1:0] len;
      r.out_byte = b;
      r.byte_position = '0;
      r.event_res = EV_DROP;
      r.declared_length = '0;
      if (frame_count == '0) begin
         if (b == shadow_cfg.sync_first) begin
            frame_count = 16'd1;
            decl_len = '0;
            r.event_res = EV_START;
         end
      end else if (frame_count == 16'd1) begin
         if (b == shadow_cfg.sync_second) begin
            frame_count = 16'd2;
            r.byte_position = 16'd1;
            r.event_res = EV_ACCEPT;
         end else if (b == shadow_cfg.sync_first) begin
            decl_len = '0;
            r.event_res = EV_START;
         end else begin
            r.byte_position = 16'd1;
            r.event_res = EV_SYNCFAIL;
            frame_count = '0;
            decl_len = '0;
         end
      end else if (frame_count == POS_MAX) begin
         frame_count = '0;
         decl_len = '0;
      end else begin
         r.byte_position = frame_count;
         frame_count = frame_count + 16'd1;
         r.event_res = EV_ACCEPT;
         if (frame_count == POS_LEN_LOW)
            len_lo = b;
         if (frame_count == POS_LEN_HIGH) begin
            len = {b, len_lo};
            if (len < shadow_cfg.min_frame_len || len > shadow_cfg.max_frame_len) begin
               r.event_res = EV_LENREJ;
               r.declared_length = len;
               frame_count = '0;
               decl_len = '0;
               return r;
            end
            decl_len = len;
         end
         r.declared_length = decl_len;
         if (decl_len != '0 && frame_count >= decl_len) begin
            r.event_res = EV_DONE;
            frame_count = '0;
            decl_len = '0;
         end
      end
      return r;
   endfunction

   task automatic report_error(input string msg);
      $display("%0t ns: MISMATCH %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [POS_W-1:0] want,
                              input logic [POS_W-1:0] got);
      if (got !== want)
         report_error($sformatf("%s: expected %0h, got %0h", name, want, got));
   endtask

   // predict on every accepted request transaction
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         pending_tags.push_back(deframe_byte(req_rx_byte));
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_tags.size() == 0) begin
            report_error("result with nothing pending");
         end else begin
            want = pending_tags.pop_front();
            check_field("out_byte", 16'(want.out_byte), 16'(rsp_out_byte));
            check_field("byte_position", want.byte_position, rsp_byte_position);
            check_field("event_res", 16'(want.event_res), 16'(rsp_event_res));
            check_field("declared_length", want.declared_length, rsp_declared_length);
         end
      end
   end

   // receiver: long hold-off first, otherwise random stalls
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write_en || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // sync pair, two filler bytes, length, then payload up to total bytes
   task automatic send_frame(input logic [POS_W-1:0] len_field, input int total);
      for (int i = 0; i < total; i++) begin
         case (i)
            0: send_byte(shadow_cfg.sync_first);
            1: send_byte(shadow_cfg.sync_second);
            4: send_byte(len_field[7:0]);
            5: send_byte(len_field[15:8]);
            default: send_byte(8'($urandom_range(255)));
         endcase
      end
   endtask

   // lower valid, wait for every pending result, then let the pipe settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_tags.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic load_config(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
                              input logic [POS_W-1:0] mn, input logic [POS_W-1:0] mx);
      csr_write(REG_SYNC_FIRST, {8'h00, s1});
      csr_write(REG_SYNC_SECOND, {8'h00, s2});
      csr_write(REG_MIN_LEN, mn);
      csr_write(REG_MAX_LEN, mx);
      shadow_cfg = '{s1, s2, mn, mx};
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      // both sync bytes 0, window 6..256 out of reset
      send_byte(8'h5A);
      send_frame(16'd6, 6);
      send_frame(16'd257, 6);
      send_frame(16'd5, 6);
      drain();
   endtask

   task automatic test_sync_faults();
      load_config(8'hFF, 8'h00, 16'd6, 16'hFFFF);
      send_byte(8'h12);
      // the frame's own first sync byte lands as a repeated first sync byte
      send_byte(8'hFF);
      send_frame(16'd8, 8);
      send_byte(8'hFF);
      send_byte(8'h7E);
      send_frame(16'd0, 6);
      drain();
   endtask

   task automatic test_length_window();
      load_config(8'h3C, 8'hC3, 16'd8, 16'd10);
      send_frame(16'd7, 6);
      send_frame(16'd11, 6);
      send_frame(16'd8, 8);
      drain();
      // inverted window rejects everything
      load_config(8'h3C, 8'hC3, 16'd300, 16'd7);
      send_frame(16'd8, 6);
      send_frame(16'hFFFF, 6);
      drain();
   endtask

   task automatic test_short_length();
      load_config(8'h00, 8'hFF, 16'd0, 16'hFFFF);
      send_frame(16'd1, 6);
      send_frame(16'd3, 6);
      send_frame(16'd6, 6);
      drain();
   endtask

   task automatic test_backpressure();
      load_config(8'hA5, 8'h5A, 16'd6, 16'd64);
      hold_cycles = 150;
      send_frame(16'd40, 40);
      drain();
   endtask

   task automatic test_random_traffic(input int goal, input int send_pct, input int rsp_pct,
                                      input bit same_sync);
      int                kind;
      int                len;
      int                lo;
      logic [BYTE_W-1:0] s1;
      logic [BYTE_W-1:0] s2;
      logic [POS_W-1:0]  mn;
      logic [POS_W-1:0]  mx;
      logic [POS_W-1:0]  bad;
      logic [BYTE_W-1:0] b;
      send_idle_pct = send_pct;
      rsp_idle_pct = rsp_pct;
      s1 = 8'($urandom_range(255));
      s2 = same_sync ? s1 : 8'($urandom_range(255));
      mn = 16'($urandom_range(0, 12));
      mx = 16'(mn + $urandom_range(0, 40));
      load_config(s1, s2, mn, mx);
      lo = (mn == '0) ? 1 : int'(mn);
      goal += items_sent;
      while (items_sent < goal) begin
         kind = $urandom_range(99);
         if (kind < 65) begin
            len = $urandom_range(lo, mx);
            send_frame(16'(len), (len < 6) ? 6 : len);
         end else if (kind < 78) begin
            if (mn > 0 && $urandom_range(1))
               bad = 16'($urandom_range(0, mn - 1));
            else
               bad = 16'($urandom_range(mx + 1, 65535));
            send_frame(bad, 6);
         end else if (kind < 86) begin
            // truncated frame: the next bytes continue it
            send_frame(16'($urandom_range(65535)), $urandom_range(1, 5));
         end else if (kind < 92) begin
            do b = 8'($urandom_range(255)); while (b == s1 || b == s2);
            send_byte(s1);
            send_byte(b);
         end else if (kind < 96) begin
            send_byte(s1);
            len = $urandom_range(lo, mx);
            send_frame(16'(len), (len < 6) ? 6 : len);
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
         end
      end
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_sync_faults();
      test_length_window();
      test_short_length();
      test_random_traffic(270, 14, 83, 1'b0);
      test_random_traffic(270, 83, 14, 1'b0);
      test_random_traffic(270, 0, 0, 1'b1);
      test_backpressure();
      if (mismatch_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

@@ sync_length_deframer.f @@
hdl/sld_pkg.sv
hdl/sld_track.sv
hdl/sld_out_reg.sv
hdl/sync_length_deframer.sv
sim/tb.sv
